// ===== src/srp_pkg.sv =====
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and constants for the SOCKS request parser.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam logic [1:0] EV_DATA = 2'd0;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_NAME  = 2'd1;
  localparam logic [1:0] KIND_CONN  = 2'd2;
  localparam logic [1:0] KIND_CLOSE = 2'd3;

  localparam logic [7:0] B_VER4  = 8'h04;
  localparam logic [7:0] B_VER5  = 8'h05;
  localparam logic [7:0] B_ONE   = 8'h01;
  localparam logic [7:0] B_THREE = 8'h03;
  localparam logic [7:0] B_ZERO  = 8'h00;
  localparam logic [7:0] B_GRANT = 8'h5a;

  typedef enum logic [2:0] {
    OP_CLOSE = 3'd0,
    OP_NAME  = 3'd1,
    OP_AUTH  = 3'd2,
    OP_S4    = 3'd3,
    OP_FIN   = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  nbyte;
    logic [31:0] addr;
    logic [15:0] port;
    logic [7:0]  ncnt;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] rb;
    logic [3:0]  rc;
    logic [7:0]  nb;
    logic        fam;
    logic [31:0] addr;
    logic [15:0] port;
    logic [7:0]  nlen;
    logic        last;
  } result_t;

endpackage

// ===== src/srp_front.sv =====
// ----------------------------------------------------------------------------
// srp_front
// Byte parser: tracks the handshake and issues commands to the back end.
// ----------------------------------------------------------------------------
module srp_front import srp_pkg::*; #(
  parameter int NAME_DEPTH = 256,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    data_byte,
  input  logic [1:0]    stream_event,
  output logic          full,
  input  logic          q_full,
  output logic          cmd_push,
  output cmd_t          cmd,
  input  logic          fin_done,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  typedef enum logic [13:0] {
    S_VER     = 14'b00000000000001,
    S_S4_CMD  = 14'b00000000000010,
    S_S4_PORT = 14'b00000000000100,
    S_S4_ADDR = 14'b00000000001000,
    S_S4_USER = 14'b00000000010000,
    S_S5_MLEN = 14'b00000000100000,
    S_S5_METH = 14'b00000001000000,
    S_S5_CMD  = 14'b00000010000000,
    S_S5_RSV  = 14'b00000100000000,
    S_S5_ATYP = 14'b00001000000000,
    S_S5_ADDR = 14'b00010000000000,
    S_S5_NLEN = 14'b00100000000000,
    S_S5_NAME = 14'b01000000000000,
    S_S5_PORT = 14'b10000000000000
  } state_t;

  state_t      st, st_next;
  logic        auth, auth_next;
  logic [31:0] addr, addr_next;
  logic [15:0] port, port_next;
  logic [7:0]  left, left_next;
  logic        noauth, noauth_next;
  logic [7:0]  cnt, cnt_next;
  logic        busy;
  logic        acc;
  logic        rst_conn;
  logic        gen;

  assign full = q_full | busy;
  assign acc  = push & ~full;

  always_comb begin
    st_next     = st;
    auth_next   = auth;
    addr_next   = addr;
    port_next   = port;
    left_next   = left;
    noauth_next = noauth;
    cnt_next    = cnt;
    rst_conn    = 1'b0;
    gen         = 1'b0;
    cmd         = '{op: OP_CLOSE, nbyte: 8'd0, addr: addr, port: port, ncnt: cnt};
    wr_en       = 1'b0;
    wr_addr     = cnt[AW-1:0];
    wr_data     = data_byte;
    if (stream_event != EV_DATA) begin
      gen = 1'b1;
      rst_conn = 1'b1;
    end else begin
      unique case (st)
        S_VER: begin
          if (data_byte == B_VER4) st_next = S_S4_CMD;
          else if (data_byte == B_VER5) st_next = auth ? S_S5_CMD : S_S5_MLEN;
          else begin gen = 1'b1; rst_conn = 1'b1; end
        end
        S_S4_CMD: begin
          if (data_byte == B_ONE) begin st_next = S_S4_PORT; left_next = 8'd2; end
          else begin gen = 1'b1; rst_conn = 1'b1; end
        end
        S_S4_PORT: begin
          port_next = {port[7:0], data_byte};
          left_next = left - 8'd1;
          if (left == 8'd1) begin st_next = S_S4_ADDR; left_next = 8'd4; end
        end
        S_S4_ADDR: begin
          addr_next = {addr[23:0], data_byte};
          left_next = left - 8'd1;
          if (left == 8'd1) st_next = S_S4_USER;
        end
        S_S4_USER: begin
          if (data_byte == B_ZERO) begin
            gen = 1'b1;
            cmd.op = OP_S4;
            rst_conn = 1'b1;
          end
        end
        S_S5_MLEN: begin
          if (data_byte == B_ZERO) begin gen = 1'b1; rst_conn = 1'b1; end
          else begin
            left_next = data_byte;
            noauth_next = 1'b0;
            st_next = S_S5_METH;
          end
        end
        S_S5_METH: begin
          if (data_byte == B_ZERO) noauth_next = 1'b1;
          left_next = left - 8'd1;
          if (left == 8'd1) begin
            gen = 1'b1;
            if (noauth || data_byte == B_ZERO) begin
              cmd.op = OP_AUTH;
              auth_next = 1'b1;
              noauth_next = 1'b0;
              st_next = S_VER;
            end else begin
              rst_conn = 1'b1;
            end
          end
        end
        S_S5_CMD: begin
          if (data_byte == B_ONE) st_next = S_S5_RSV;
          else begin gen = 1'b1; rst_conn = 1'b1; end
        end
        S_S5_RSV: begin
          if (data_byte == B_ZERO) st_next = S_S5_ATYP;
          else begin gen = 1'b1; rst_conn = 1'b1; end
        end
        S_S5_ATYP: begin
          if (data_byte == B_ONE) begin st_next = S_S5_ADDR; left_next = 8'd4; end
          else if (data_byte == B_THREE) st_next = S_S5_NLEN;
          else begin gen = 1'b1; rst_conn = 1'b1; end
        end
        S_S5_ADDR: begin
          addr_next = {addr[23:0], data_byte};
          left_next = left - 8'd1;
          if (left == 8'd1) begin st_next = S_S5_PORT; left_next = 8'd2; end
        end
        S_S5_NLEN: begin
          if (data_byte == B_ZERO) begin st_next = S_S5_PORT; left_next = 8'd2; end
          else begin st_next = S_S5_NAME; left_next = data_byte; end
        end
        S_S5_NAME: begin
          wr_en = ({1'b0, cnt} < 9'(NAME_DEPTH));
          cnt_next = cnt + 8'd1;
          gen = 1'b1;
          cmd.op = OP_NAME;
          cmd.nbyte = data_byte;
          left_next = left - 8'd1;
          if (left == 8'd1) begin st_next = S_S5_PORT; left_next = 8'd2; end
        end
        S_S5_PORT: begin
          port_next = {port[7:0], data_byte};
          left_next = left - 8'd1;
          if (left == 8'd1) begin
            gen = 1'b1;
            cmd.op = OP_FIN;
            cmd.port = port_next;
            rst_conn = 1'b1;
          end
        end
        default: begin
          gen = 1'b1;
          rst_conn = 1'b1;
        end
      endcase
    end
    if (rst_conn) begin
      st_next     = S_VER;
      auth_next   = 1'b0;
      addr_next   = 32'd0;
      port_next   = 16'd0;
      left_next   = 8'd0;
      noauth_next = 1'b0;
      cnt_next    = 8'd0;
    end
    cmd_push = acc & gen;
    wr_en    = wr_en & acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_VER;
      auth   <= 1'b0;
      addr   <= 32'd0;
      port   <= 16'd0;
      left   <= 8'd0;
      noauth <= 1'b0;
      cnt    <= 8'd0;
      busy   <= 1'b0;
    end else begin
      if (acc) begin
        st     <= st_next;
        auth   <= auth_next;
        addr   <= addr_next;
        port   <= port_next;
        left   <= left_next;
        noauth <= noauth_next;
        cnt    <= cnt_next;
      end
      if (cmd_push && cmd.op == OP_FIN) busy <= 1'b1;
      else if (fin_done) busy <= 1'b0;
    end
  end

endmodule

// ===== src/srp_fifo.sv =====
// ----------------------------------------------------------------------------
// srp_fifo
// Two-entry command queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module srp_fifo import srp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wdata,
  output logic q_full,
  input  logic rd,
  output logic q_valid,
  output cmd_t rdata
);

  cmd_t       slots [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign q_full  = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign rdata   = slots[rp];

  always_ff @(posedge clk) begin
    if (wr) slots[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

endmodule

// ===== src/srp_back.sv =====
// ----------------------------------------------------------------------------
// srp_back
// Result sequencer: turns commands into result beats, owns the name store.
// ----------------------------------------------------------------------------
module srp_back import srp_pkg::*; #(
  parameter int NAME_DEPTH = 256,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          q_valid,
  input  cmd_t          head,
  output logic          q_pop,
  output logic          fin_done,
  input  logic          pop,
  output logic          o_valid,
  output result_t       o_res
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_RD   = 5'b00010,
    B_WR   = 5'b00100,
    B_EMIT = 5'b01000,
    B_CONN = 5'b10000
  } bstate_t;

  logic [7:0] store [NAME_DEPTH];

  bstate_t     st, st_next;
  logic [8:0]  pos, pos_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  cnt, cnt_next;
  logic [7:0]  mem_q, byte_q, cbyte, wbyte, idx;
  logic        from_mem_q, in_range_q, from_mem;
  logic        is03, can_out, emit;
  logic [8:0]  n;
  result_t     res;

  assign can_out  = ~o_valid | pop;
  assign is03     = (head.ncnt != 8'd0) || (head.addr == 32'd0);
  assign n        = is03 ? 9'd7 + {1'b0, head.ncnt} : 9'd10;
  assign idx      = 8'(pos - 9'd5);
  assign from_mem = is03 && pos >= 9'd5 && pos < n - 9'd2;
  assign fin_done = q_pop && head.op == OP_FIN;

  always_comb begin
    priority if (pos == 9'd0) cbyte = B_VER5;
    else if (pos == 9'd1 || pos == 9'd2) cbyte = B_ZERO;
    else if (pos == 9'd3) cbyte = is03 ? B_THREE : B_ONE;
    else if (pos == n - 9'd2) cbyte = head.port[15:8];
    else if (pos == n - 9'd1) cbyte = head.port[7:0];
    else if (is03) cbyte = head.ncnt;
    else if (pos == 9'd4) cbyte = head.addr[31:24];
    else if (pos == 9'd5) cbyte = head.addr[23:16];
    else if (pos == 9'd6) cbyte = head.addr[15:8];
    else cbyte = head.addr[7:0];
  end

  assign wbyte = from_mem_q ? (in_range_q ? mem_q : 8'd0) : byte_q;

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
    mem_q      <= store[idx[AW-1:0]];
    in_range_q <= ({1'b0, idx} < 9'(NAME_DEPTH));
    from_mem_q <= from_mem;
    byte_q     <= cbyte;
  end

  always_comb begin
    st_next  = st;
    pos_next = pos;
    acc_next = acc;
    cnt_next = cnt;
    emit     = 1'b0;
    q_pop    = 1'b0;
    res      = '0;
    unique case (st)
      B_IDLE: begin
        if (q_valid && can_out) begin
          unique case (head.op)
            OP_CLOSE: begin
              emit = 1'b1; q_pop = 1'b1;
              res.kind = KIND_CLOSE; res.last = 1'b1;
            end
            OP_NAME: begin
              emit = 1'b1; q_pop = 1'b1;
              res.kind = KIND_NAME; res.nb = head.nbyte; res.last = 1'b1;
            end
            OP_AUTH: begin
              emit = 1'b1; q_pop = 1'b1;
              res.kind = KIND_REPLY; res.rb = {B_VER5, B_ZERO, 48'd0};
              res.rc = 4'd2; res.last = 1'b1;
            end
            OP_S4: begin
              emit = 1'b1;
              res.kind = KIND_REPLY; res.rb = {B_ZERO, B_GRANT, 48'd0};
              res.rc = 4'd8;
              st_next = B_CONN;
            end
            OP_FIN: begin
              pos_next = 9'd0; acc_next = 64'd0; cnt_next = 4'd0;
              st_next = B_RD;
            end
            default: begin
              emit = 1'b1; q_pop = 1'b1;
              res.kind = KIND_CLOSE; res.last = 1'b1;
            end
          endcase
        end
      end
      B_RD: st_next = B_WR;
      B_WR: begin
        acc_next = acc | ({wbyte, 56'd0} >> {cnt, 3'b000});
        cnt_next = cnt + 4'd1;
        pos_next = pos + 9'd1;
        st_next  = (cnt_next == 4'd8 || pos_next == n) ? B_EMIT : B_RD;
      end
      B_EMIT: begin
        if (can_out) begin
          emit = 1'b1;
          res.kind = KIND_REPLY; res.rb = acc; res.rc = cnt;
          acc_next = 64'd0; cnt_next = 4'd0;
          st_next = (pos == n) ? B_CONN : B_RD;
        end
      end
      B_CONN: begin
        if (can_out) begin
          emit = 1'b1; q_pop = 1'b1;
          res.kind = KIND_CONN; res.port = head.port; res.last = 1'b1;
          if (head.op == OP_FIN && head.ncnt != 8'd0) begin
            res.fam = 1'b1; res.nlen = head.ncnt;
          end else begin
            res.addr = head.addr;
          end
          st_next = B_IDLE;
        end
      end
      default: st_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= B_IDLE;
      o_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (emit) o_valid <= 1'b1;
      else if (pop) o_valid <= 1'b0;
    end
    pos <= pos_next;
    acc <= acc_next;
    cnt <= cnt_next;
    if (emit) o_res <= res;
  end

`ifndef SYNTH
  a_rd_wr: assert property (@(posedge clk) disable iff (rst) st == B_RD |=> st == B_WR)
    else $error("read step not followed by write step");
  a_cnt: assert property (@(posedge clk) disable iff (rst) st != B_IDLE |-> cnt <= 4'd8)
    else $error("reply word overfilled");
  a_pop: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid && emit)
    else $error("command retired without a beat");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    o_valid && !pop |=> o_valid && $stable(o_res))
    else $error("pending result beat changed");
`endif

endmodule

// ===== src/socks_request_parser.sv =====
// ----------------------------------------------------------------------------
// socks_request_parser
// SOCKS4/SOCKS5 connect handshake parser, one client byte per beat.
// ----------------------------------------------------------------------------
// Result path: command queue, then output register; a SOCKS5 final reply has
//   read and write steps per byte, an emit per word, then the connect beat.
// Throughput: one byte per cycle while parsing; input stalls while the
//   SOCKS5 final reply is built from the name store, or the queue is full.
// Reset: synchronous, clears parser, command queue and output register.
module socks_request_parser import srp_pkg::*; #(
  parameter int NAME_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic [1:0]  stream_event,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [63:0] reply_bytes,
  output logic [3:0]  reply_count,
  output logic [7:0]  name_byte,
  output logic        target_family,
  output logic [31:0] target_address,
  output logic [15:0] target_port,
  output logic [7:0]  name_length,
  output logic        last
);

  localparam int AW = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;

  logic          q_full, cmd_push, q_valid, q_pop, fin_done, wr_en, o_valid;
  cmd_t          cmd, head;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  result_t       o_res;

  srp_front #(.NAME_DEPTH(NAME_DEPTH), .AW(AW)) u_front (
    .clk, .rst, .push, .data_byte, .stream_event, .full, .q_full,
    .cmd_push, .cmd, .fin_done, .wr_en, .wr_addr, .wr_data
  );

  srp_fifo u_fifo (
    .clk, .rst, .wr(cmd_push), .wdata(cmd), .q_full,
    .rd(q_pop), .q_valid, .rdata(head)
  );

  srp_back #(.NAME_DEPTH(NAME_DEPTH), .AW(AW)) u_back (
    .clk, .rst, .wr_en, .wr_addr, .wr_data, .q_valid, .head, .q_pop,
    .fin_done, .pop, .o_valid, .o_res
  );

  assign empty          = ~o_valid;
  assign result_kind    = o_res.kind;
  assign reply_bytes    = o_res.rb;
  assign reply_count    = o_res.rc;
  assign name_byte      = o_res.nb;
  assign target_family  = o_res.fam;
  assign target_address = o_res.addr;
  assign target_port    = o_res.port;
  assign name_length    = o_res.nlen;
  assign last           = o_res.last;

endmodule
